// File: hw/rtl/cst_pkg.sv
`default_nettype none

package cst_pkg;

   typedef enum logic [1:0] {
      KIND_CREATE  = 2'd0,
      KIND_WAIT    = 2'd1,
      KIND_SIGNAL  = 2'd2,
      KIND_DESTROY = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_BAD_ID    = 3'd1,
      STATUS_NO_SLOT   = 3'd2,
      STATUS_NOT_OWNER = 3'd3,
      STATUS_FULL      = 3'd4
   } status_type;

   localparam int SEM_ID_W  = 4;
   localparam int COUNT_W   = 16;
   localparam int TASK_W    = 16;
   localparam logic signed [COUNT_W-1:0] COUNT_MIN = 16'sh8000;
   localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sh7fff;

   typedef struct packed {
      kind_type                   kind;
      logic [SEM_ID_W-1:0]        sem_id;
      logic signed [COUNT_W-1:0]  init_value;
      logic [TASK_W-1:0]          caller_task;
   } req_type;

   typedef struct packed {
      status_type           status;
      logic [SEM_ID_W-1:0]  sem_index;
      logic                 caller_blocked;
      logic                 woken_valid;
      logic [TASK_W-1:0]    woken_task;
      logic                 last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_EVAL  = 2'd1,
      ST_POP   = 2'd2,
      ST_DRAIN = 2'd3
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;
      logic eval;
      logic pop;
      logic drain;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic go_pop;
      logic go_drain;
      logic drain_last;
   } dp_status_type;

endpackage

`default_nettype wire

// File: hw/rtl/counting_semaphore_table.sv
`default_nettype none

// Channel   | Ports                       | Beat taken when
// ----------+-----------------------------+-------------------------------
// request   | start, busy, req_item       | rising edge with start & !busy
// response  | rsp_valid, rsp_item         | rising edge ending a rsp_valid cycle
//
// Create, wait, bad id, non-owner destroy and non-waking signal: table RAM read,
// then evaluate; the beat shows in the next cycle, when the next request can be
// taken. A waking signal adds a pop state, an owner's destroy a drain state per
// waiter: the registered waiter stack RAM gives one entry a cycle. Synchronous
// reset frees every slot; table and stack RAMs are not cleared, since create
// writes a slot before it is read. The response side cannot stall.

module counting_semaphore_table #(
   parameter int NUM_SEMS     = 16,
   parameter int MAX_WAITERS  = 16,
   parameter int TASK_ID_BITS = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire cst_pkg::req_type req_item,
   output logic                  rsp_valid,
   output cst_pkg::rsp_type      rsp_item
);

   import cst_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type sts;

   // sequencing: idle -> evaluate -> (pop | drain loop) -> idle
   cst_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .sts   (sts)
   );

   // slot table, waiter stacks, count arithmetic and response register
   cst_datapath #(
      .NUM_SEMS     (NUM_SEMS),
      .MAX_WAITERS  (MAX_WAITERS),
      .TASK_ID_BITS (TASK_ID_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire

// File: hw/rtl/cst_ram.sv
`default_nettype none

module cst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/cst_ctrl.sv
`default_nettype none

module cst_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   output cst_pkg::ctrl_cmd_type      cmd,
   input  wire cst_pkg::dp_status_type sts
);

   import cst_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            if (sts.go_pop) begin
               state_in = ST_POP;
            end else if (sts.go_drain) begin
               state_in = ST_DRAIN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_POP: begin
            cmd.pop  = 1'b1;
            state_in = ST_IDLE;
         end
         ST_DRAIN: begin
            cmd.drain = 1'b1;
            if (sts.drain_last) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

// File: hw/rtl/cst_datapath.sv
`default_nettype none

module cst_datapath #(
   parameter int NUM_SEMS     = 16,
   parameter int MAX_WAITERS  = 16,
   parameter int TASK_ID_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cst_pkg::ctrl_cmd_type cmd,
   output cst_pkg::dp_status_type     sts,
   input  wire cst_pkg::req_type      req_item,
   output logic                       rsp_valid,
   output cst_pkg::rsp_type           rsp_item
);

   import cst_pkg::*;

   localparam int TW  = (TASK_ID_BITS < TASK_W) ? TASK_ID_BITS : TASK_W;
   localparam int SW  = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
   localparam int DW  = $clog2(MAX_WAITERS + 1);
   localparam int XW  = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
   localparam int STK_DEPTH = NUM_SEMS * MAX_WAITERS;
   localparam int AW  = (STK_DEPTH > 1) ? $clog2(STK_DEPTH) : 1;
   localparam int SLW = COUNT_W + TW + DW;

   // request and control registers
   req_type              req_ff;
   logic [NUM_SEMS-1:0]  used_ff, used_in;
   logic [DW-1:0]        drain_cnt_ff, drain_cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   // slot table RAM: {count, owner, depth}
   logic           slot_wr_en;
   logic [SW-1:0]  slot_wr_addr;
   logic [SLW-1:0] slot_wr_data;
   logic [SW-1:0]  slot_rd_addr;
   logic [SLW-1:0] slot_rd_data;

   // waiter stack RAM
   logic           stk_wr_en;
   logic [AW-1:0]  stk_wr_addr;
   logic [TW-1:0]  stk_wr_data;
   logic           stk_rd_en;
   logic [AW-1:0]  stk_rd_addr;
   logic [TW-1:0]  stk_rd_data;

   logic [SW-1:0]             slot_sel;
   logic [AW-1:0]             stk_base;
   logic                      id_ok;
   logic                      free_found;
   logic [SW-1:0]             free_idx;
   logic [TW-1:0]             caller_t;
   logic signed [COUNT_W-1:0] cur_count;
   logic [TW-1:0]             cur_owner;
   logic [DW-1:0]             cur_depth;
   logic signed [COUNT_W-1:0] cnt_dec;
   logic signed [COUNT_W-1:0] cnt_inc;

   cst_ram #(.WIDTH(SLW), .DEPTH(NUM_SEMS)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_data (slot_wr_data),
      .rd_en   (cmd.accept),
      .rd_addr (slot_rd_addr),
      .rd_data (slot_rd_data)
   );

   cst_ram #(.WIDTH(TW), .DEPTH(STK_DEPTH)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_en   (stk_rd_en),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   assign slot_rd_addr = SW'({{SW{1'b0}}, req_item.sem_id});
   assign slot_sel     = SW'({{SW{1'b0}}, req_ff.sem_id});
   assign stk_base     = AW'(AW'(slot_sel) * AW'(MAX_WAITERS));
   assign caller_t     = req_ff.caller_task[TW-1:0];

   assign cur_count = slot_rd_data[SLW-1 -: COUNT_W];
   assign cur_owner = slot_rd_data[DW +: TW];
   assign cur_depth = slot_rd_data[DW-1:0];

   // saturating count steps
   assign cnt_dec = (cur_count == COUNT_MIN) ? cur_count : cur_count - 16'sd1;
   assign cnt_inc = (cur_count == COUNT_MAX) ? cur_count : cur_count + 16'sd1;

   always_comb begin
      id_ok = ({{(32 - SEM_ID_W){1'b0}}, req_ff.sem_id} < 32'(NUM_SEMS))
              && used_ff[slot_sel];
   end

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = NUM_SEMS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SW'(i);
         end
      end
   end

   always_comb begin
      used_in      = used_ff;
      drain_cnt_in = drain_cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      rsp_in.status = STATUS_OK;
      rsp_in.last  = 1'b1;
      slot_wr_en   = 1'b0;
      slot_wr_addr = slot_sel;
      slot_wr_data = {cur_count, cur_owner, cur_depth};
      stk_wr_en    = 1'b0;
      stk_wr_addr  = stk_base + AW'(XW'(cur_depth));
      stk_wr_data  = caller_t;
      stk_rd_en    = 1'b0;
      stk_rd_addr  = stk_base + AW'(XW'(cur_depth - DW'(1)));
      sts          = '0;

      if (cmd.eval) begin
         if (req_ff.kind == KIND_CREATE) begin
            rsp_valid_in = 1'b1;
            if (free_found) begin
               used_in[free_idx] = 1'b1;
               slot_wr_en        = 1'b1;
               slot_wr_addr      = free_idx;
               slot_wr_data      = {req_ff.init_value, caller_t, {DW{1'b0}}};
               rsp_in.sem_index  = SEM_ID_W'({{SEM_ID_W{1'b0}}, free_idx});
            end else begin
               rsp_in.status = STATUS_NO_SLOT;
            end
         end else if (!id_ok) begin
            rsp_valid_in  = 1'b1;
            rsp_in.status = STATUS_BAD_ID;
         end else begin
            unique case (req_ff.kind)
               KIND_WAIT: begin
                  rsp_valid_in = 1'b1;
                  if (cnt_dec[COUNT_W-1]) begin
                     if (cur_depth >= DW'(MAX_WAITERS)) begin
                        rsp_in.status = STATUS_FULL;
                     end else begin
                        stk_wr_en    = 1'b1;
                        slot_wr_en   = 1'b1;
                        slot_wr_data = {cnt_dec, cur_owner, cur_depth + DW'(1)};
                        rsp_in.caller_blocked = 1'b1;
                     end
                  end else begin
                     slot_wr_en   = 1'b1;
                     slot_wr_data = {cnt_dec, cur_owner, cur_depth};
                  end
               end
               KIND_SIGNAL: begin
                  slot_wr_en = 1'b1;
                  if ((cnt_inc[COUNT_W-1] || cnt_inc == '0) && cur_depth != '0) begin
                     // pop newest waiter; result goes out once the stack read lands
                     slot_wr_data = {cnt_inc, cur_owner, cur_depth - DW'(1)};
                     stk_rd_en    = 1'b1;
                     sts.go_pop   = 1'b1;
                  end else begin
                     slot_wr_data = {cnt_inc, cur_owner, cur_depth};
                     rsp_valid_in = 1'b1;
                  end
               end
               KIND_DESTROY: begin
                  if (cur_owner != caller_t) begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = STATUS_NOT_OWNER;
                  end else begin
                     used_in[slot_sel] = 1'b0;
                     if (cur_depth == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        stk_rd_en    = 1'b1;
                        drain_cnt_in = cur_depth;
                        sts.go_drain = 1'b1;
                     end
                  end
               end
               KIND_CREATE: begin
                  rsp_valid_in = 1'b1;
               end
            endcase
         end
      end

      if (cmd.pop) begin
         rsp_valid_in       = 1'b1;
         rsp_in.woken_valid = 1'b1;
         rsp_in.woken_task  = TASK_W'({{TASK_W{1'b0}}, stk_rd_data});
      end

      if (cmd.drain) begin
         rsp_valid_in       = 1'b1;
         rsp_in.woken_valid = 1'b1;
         rsp_in.woken_task  = TASK_W'({{TASK_W{1'b0}}, stk_rd_data});
         sts.drain_last     = (drain_cnt_ff == DW'(1));
         rsp_in.last        = sts.drain_last;
         if (!sts.drain_last) begin
            stk_rd_en    = 1'b1;
            stk_rd_addr  = stk_base + AW'(XW'(drain_cnt_ff - DW'(2)));
            drain_cnt_in = drain_cnt_ff - DW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff <= req_item;
      end
      drain_cnt_ff <= drain_cnt_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

`default_nettype wire
